### design/rhts_pkg.sv
// Package: shared constants, op codes and cell control type for the text matcher
`timescale 1ns / 1ps
package rhts_pkg;

  // Pattern capacity and field widths
  localparam int MAX_PATTERN = 32;
  localparam int CHAR_W      = 21;
  localparam int POS_W       = 32;
  localparam int CNT_W       = $clog2(MAX_PATTERN + 1);

  // Request op codes
  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2
  } op_t;

  // Shift enables broadcast along the cell row
  typedef struct packed {
    logic shift_text;
    logic shift_pat;
  } cell_ctrl_t;

endpackage

### design/rhts_cell.sv
// One cell of the match row: holds a window character and a pattern character
`timescale 1ns / 1ps
module rhts_cell
  import rhts_pkg::*;
(
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic              en,
  input  logic [CHAR_W-1:0] txt_in,
  input  logic [CHAR_W-1:0] pat_in,
  output logic [CHAR_W-1:0] txt_out,
  output logic [CHAR_W-1:0] pat_out,
  output logic              hit
);

  logic [CHAR_W-1:0] txt_r;
  logic [CHAR_W-1:0] pat_r;

  // Window and pattern characters move one cell along on their shift
  always_ff @(posedge clk) begin
    if (ctrl.shift_text) begin
      txt_r <= txt_in;
    end
    if (ctrl.shift_pat) begin
      pat_r <= pat_in;
    end
  end

  // Compare the character arriving this cycle with the held pattern character;
  // cells beyond the pattern length always agree
  assign hit     = !en || (txt_in == pat_r);
  assign txt_out = txt_r;
  assign pat_out = pat_r;

endmodule

### design/rolling_hash_text_search.sv
// The result of an accepted request is registered in the output register.
// One request per cycle while the output is not stalled; the whole window is compared in parallel by the
// row of MAX_PATTERN cells, each matching one window character against one pattern one.
// Input is taken whenever the output register is empty or being emptied.
// Reset (rst_n, synchronous, active low): empty pattern, text position zero,
// no result pending; stored characters are left as they are.
`timescale 1ns / 1ps
module rolling_hash_text_search
  import rhts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [CHAR_W-1:0] in_char_code,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_match,
  output logic [POS_W-1:0]  out_match_start,
  output logic              out_status
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_match_r, out_match_nxt;
  logic [POS_W-1:0] out_start_r, out_start_nxt;
  logic             out_status_r, out_status_nxt;

  logic             accept;
  op_t              op;
  cell_ctrl_t       ctrl;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] count_ext;
  logic             all_hit;

  logic [MAX_PATTERN-1:0] cell_en;
  logic [MAX_PATTERN-1:0] hits;
  logic [CHAR_W-1:0]      txt_chain [MAX_PATTERN];
  logic [CHAR_W-1:0]      pat_chain [MAX_PATTERN];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign op       = op_t'(in_op);

  // Row of cells; cell 0 takes the new character, the rest take their neighbour's
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [CHAR_W-1:0] txt_src;
    logic [CHAR_W-1:0] pat_src;

    if (k == 0) begin : g_head
      assign txt_src = in_char_code;
      assign pat_src = in_char_code;
    end else begin : g_body
      assign txt_src = txt_chain[k-1];
      assign pat_src = pat_chain[k-1];
    end

    assign cell_en[k] = (CNT_W'(k) < count_r);

    rhts_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .en      (cell_en[k]),
      .txt_in  (txt_src),
      .pat_in  (pat_src),
      .txt_out (txt_chain[k]),
      .pat_out (pat_chain[k]),
      .hit     (hits[k])
    );
  end

  assign all_hit   = &hits;
  assign pos_inc   = (pos_r == {POS_W{1'b1}}) ? pos_r : pos_r + POS_W'(1);
  assign count_ext = POS_W'(count_r);

  // Request decode, counters and result
  always_comb begin
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    ctrl           = '0;
    out_valid_nxt  = out_valid_r;
    out_match_nxt  = out_match_r;
    out_start_nxt  = out_start_r;
    out_status_nxt = out_status_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      out_valid_nxt  = 1'b1;
      out_match_nxt  = 1'b0;
      out_start_nxt  = '0;
      out_status_nxt = 1'b0;
      case (op)
        OP_CLEAR: begin
          count_nxt = '0;
          pos_nxt   = '0;
        end
        OP_PATTERN: begin
          if (count_r == CNT_W'(MAX_PATTERN)) begin
            out_status_nxt = 1'b1;
          end else begin
            count_nxt      = count_r + CNT_W'(1);
            pos_nxt        = '0;
            ctrl.shift_pat = 1'b1;
          end
        end
        OP_TEXT: begin
          ctrl.shift_text = 1'b1;
          pos_nxt         = pos_inc;
          if ((count_r != '0) && (pos_inc >= count_ext) && all_hit) begin
            out_match_nxt = 1'b1;
            out_start_nxt = pos_inc - count_ext;
          end
        end
        default: begin
          // unused code: all-zero result, nothing changes
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_match_r  <= out_match_nxt;
    out_start_r  <= out_start_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_match       = out_match_r;
  assign out_match_start = out_start_r;
  assign out_status      = out_status_r;

  // Pattern length never exceeds the cell row
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PATTERN))
    else $error("pattern count beyond capacity");

  // A match and a dropped pattern character never share one result
  a_match_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_match_r |-> !out_status_r)
    else $error("match and status both set");

  // A clear empties the pattern and restarts the text
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_op == OP_CLEAR) |=> (count_r == '0) && (pos_r == '0))
    else $error("clear did not restart");

  // A matching window always starts before the current position
  a_start_bound: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_op == OP_TEXT) |=> !out_match_r || (out_start_r < pos_r))
    else $error("match start beyond position");

  // A pending result is never overwritten while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_start_r))
    else $error("stalled result lost");

endmodule

### sim/tb_rolling_hash_text_search.sv
// Testbench for the rolling-hash text matcher: directed table, then random pattern/text runs.
`timescale 1ns / 1ps
module tb_rolling_hash_text_search
  import rhts_pkg::*;
();

  localparam int          ITEMS    = 1600;
  localparam int          LIMIT    = 500000;
  localparam int          DRAIN    = 8;
  localparam int          HOLD_AT  = 300;
  localparam int          HOLD_LEN = 150;
  localparam logic [20:0] CHAR_TOP = 21'd1114111;
  localparam logic [63:0] MODULUS  = 64'd33554393;
  localparam logic [63:0] RADIX    = 64'd1114112;

  typedef struct packed {
    logic        match;
    logic [31:0] start;
    logic        status;
  } result_t;

  typedef struct packed {
    op_t         op;
    logic [20:0] ch;
    bit          pinned;
    result_t     want;
  } step_t;

  localparam result_t NONE = '{1'b0, 32'd0, 1'b0};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_op = OP_CLEAR;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_match;
  logic [POS_W-1:0]  out_match_start;
  logic              out_status;

  rolling_hash_text_search dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_char_code   (in_char_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_match      (out_match),
    .out_match_start(out_match_start),
    .out_status     (out_status)
  );

  always #4 clk = ~clk;

  // Shadow state of the matcher
  logic [20:0] pat_chars [MAX_PATTERN];
  logic [20:0] win_chars [MAX_PATTERN];
  int unsigned pat_len = 0;
  logic [24:0] pat_sig = '0;
  logic [24:0] win_sig = '0;
  logic [24:0] top_weight = 25'd1;
  logic [31:0] text_pos = '0;

  result_t     pending [$];
  int          mismatches = 0;
  int          sent = 0;
  int          burst_left = 0;
  int          cycles = 0;

  // Directed requests; pinned rows carry a hand-written result
  step_t plan [0:16] = '{
    '{OP_TEXT,    21'd0,       1'b1, NONE},                    // empty pattern, no match
    '{OP_CLEAR,   CHAR_TOP,    1'b1, NONE},
    '{OP_PATTERN, CHAR_TOP,    1'b1, NONE},
    '{OP_TEXT,    CHAR_TOP,    1'b1, '{1'b1, 32'd0, 1'b0}},
    '{OP_TEXT,    21'd5,       1'b0, NONE},
    '{OP_TEXT,    CHAR_TOP,    1'b1, '{1'b1, 32'd2, 1'b0}},
    '{OP_PATTERN, 21'd0,       1'b1, NONE},                    // append after text restarts it
    '{OP_TEXT,    CHAR_TOP,    1'b1, NONE},                    // window not yet full
    '{OP_TEXT,    21'd0,       1'b1, '{1'b1, 32'd0, 1'b0}},
    '{OP_CLEAR,   21'd0,       1'b1, NONE},
    // hashes collide on 30,200000 but the characters differ
    '{OP_PATTERN, 21'd0,       1'b0, NONE},
    '{OP_PATTERN, 21'd68967,   1'b0, NONE},
    '{OP_TEXT,    21'd30,      1'b0, NONE},
    '{OP_TEXT,    21'd200000,  1'b0, NONE},
    '{OP_TEXT,    21'd0,       1'b0, NONE},
    '{OP_TEXT,    21'd68967,   1'b0, NONE},
    '{OP_TEXT,    21'd1048576, 1'b0, NONE}
  };

  function automatic logic [24:0] sig_push(logic [24:0] h, logic [20:0] c);
    logic [63:0] acc;
    acc = 64'(h) * RADIX + (64'(c) % MODULUS);
    return 25'(acc % MODULUS);
  endfunction

  function automatic bit window_is_pattern(int unsigned m);
    bit same;
    same = 1'b1;
    for (int k = 0; k < m; k++) begin
      if (win_chars[k] != pat_chars[m - 1 - k]) same = 1'b0;
    end
    return same;
  endfunction

  // Advance the shadow state by one request and give its result
  task automatic predict_result(input op_t op, input logic [20:0] ch, output result_t r);
    logic [63:0] drop;
    int unsigned m;
    r = NONE;
    case (op)
      OP_CLEAR: begin
        pat_len    = 0;
        pat_sig    = '0;
        top_weight = 25'd1;
        win_sig    = '0;
        text_pos   = '0;
      end
      OP_PATTERN: begin
        if (pat_len >= MAX_PATTERN) begin
          r.status = 1'b1;
        end else begin
          if (pat_len > 0) top_weight = 25'((64'(top_weight) * RADIX) % MODULUS);
          pat_chars[pat_len] = ch;
          pat_len++;
          pat_sig  = sig_push(pat_sig, ch);
          win_sig  = '0;
          text_pos = '0;
        end
      end
      OP_TEXT: begin
        m = pat_len;
        // remove the character leaving the window
        if (m > 0 && text_pos >= m) begin
          drop    = ((64'(win_chars[m - 1]) % MODULUS) * 64'(top_weight)) % MODULUS;
          win_sig = 25'((64'(win_sig) + MODULUS - drop) % MODULUS);
        end
        win_sig = sig_push(win_sig, ch);
        for (int k = MAX_PATTERN - 1; k > 0; k--) win_chars[k] = win_chars[k - 1];
        win_chars[0] = ch;
        if (text_pos != '1) text_pos++;
        if (m > 0 && text_pos >= m && win_sig == pat_sig && window_is_pattern(m)) begin
          r.match = 1'b1;
          r.start = text_pos - m;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one request in bursts with random gaps; record its result once taken
  task automatic send(input op_t op, input logic [20:0] ch, input bit pinned = 1'b0,
                      input result_t want = NONE);
    int gap;
    result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 19))
        0:             gap = $urandom_range(10, 20);
        1, 2, 3, 4, 5,
        6, 7:          gap = 0;
        default:       gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_op        <= op;
    in_char_code <= ch;
    do @(posedge clk); while (!in_ready);
    predict_result(op, ch, r);
    pending.insert(pending.size(), pinned ? want : r);
    sent++;
  endtask

  function automatic logic [20:0] pick_char(input logic [20:0] set [3], input int n);
    if ($urandom_range(0, 9) == 0) return 21'($urandom_range(0, CHAR_TOP));
    return set[$urandom_range(0, n - 1)];
  endfunction

  // One pattern load followed by text drawn mostly from a small alphabet, with pattern copies and clears
  task automatic run_sequence(input bit force_long);
    logic [20:0] set [3];
    logic [20:0] pat [$];
    logic [20:0] c;
    int n_set, plen, tlen, roll;
    n_set = $urandom_range(1, 3);
    foreach (set[i]) set[i] = 21'($urandom_range(0, CHAR_TOP));
    if (force_long || $urandom_range(0, 3) != 0) send(OP_CLEAR, 21'($urandom_range(0, CHAR_TOP)));
    // text against an empty or stale pattern
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) send(OP_TEXT, pick_char(set, n_set));
    end
    roll = $urandom_range(0, 9);
    if (force_long)    plen = MAX_PATTERN + 2;
    else if (roll < 7) plen = $urandom_range(1, 4);
    else if (roll < 9) plen = $urandom_range(5, 12);
    else               plen = $urandom_range(13, MAX_PATTERN + 2);
    for (int i = 0; i < plen; i++) begin
      c = pick_char(set, n_set);
      send(OP_PATTERN, c);
      if (pat.size() < MAX_PATTERN) pat.insert(pat.size(), c);
    end
    tlen = $urandom_range(8, 40);
    for (int i = 0; i < tlen; i++) begin
      roll = $urandom_range(0, 99);
      if (force_long && i == 0 || roll < 12) begin
        foreach (pat[j]) send(OP_TEXT, pat[j]);
      end else if (roll < 14) begin
        send(OP_CLEAR, 21'($urandom_range(0, CHAR_TOP)));
      end else begin
        send(OP_TEXT, pick_char(set, n_set));
      end
    end
  endtask

  // Stimulus and end of run
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (plan[i]) send(plan[i].op, plan[i].ch, plan[i].pinned, plan[i].want);
    run_sequence(1'b1);
    while (sent < ITEMS) run_sequence(1'b0);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: changing stall pattern plus one long hold-off
  int rx_cycle = 0;
  int rx_mode = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle == HOLD_AT) hold_left = HOLD_LEN;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 0);
        2:       out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        report("result with nothing pending", {31'd0, out_match}, 32'd0);
      end else begin
        want = pending[0];
        pending.delete(0);
        if (out_match !== want.match) report("match", {31'd0, out_match}, {31'd0, want.match});
        if (out_match_start !== want.start) report("match_start", out_match_start, want.start);
        if (out_status !== want.status)
          report("status", {31'd0, out_status}, {31'd0, want.status});
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

### filelist.f
design/rhts_pkg.sv
design/rhts_cell.sv
design/rolling_hash_text_search.sv
sim/tb_rolling_hash_text_search.sv
